// ===== rtl/bfpm_pkg.sv =====
// Package for the brute-force pattern matcher: sizes, request codes,
// payload structs and the command/status bundles between control and datapath.
// No dependencies.
package bfpm_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int TEXT_MAX    = 4096;

  localparam int SYM_W   = 8;
  localparam int FIELD_W = 13;
  localparam int PLEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int PADDR_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int POS_W   = $clog2(TEXT_MAX + 1);
  localparam int CMP_W   = (POS_W > PLEN_W) ? POS_W : PLEN_W;
  localparam int AS_W    = PLEN_W + 1;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_BEGIN   = 2'd0;
  localparam logic [1:0] REQ_PATTERN = 2'd1;
  localparam logic [1:0] REQ_TEXT    = 2'd2;
  localparam logic [1:0] REQ_END     = 2'd3;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [SYM_W-1:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic               match_hit;
    logic [FIELD_W-1:0] match_start;
    logic [FIELD_W-1:0] match_total;
    logic               any_found;
    logic               search_done;
    logic               pattern_overflow;
  } out_item_t;

  typedef struct packed {
    logic take;    // input transaction accepted this cycle
    logic issue;   // issue one compare read pair
    logic finish;  // last compare data is present, close the item
  } ctrl_cmd_t;

  typedef struct packed {
    logic res_block;   // result buffer full and not draining
    logic need_scan;   // offered text byte needs a window compare
    logic last_issue;  // current read pair is the last one
  } dp_sts_t;

endpackage

// ===== rtl/bfpm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bfpm_ctrl.sv =====
// Controller state machine for the pattern matcher: accepts transactions and
// sequences the window compare. Depends on bfpm_pkg.
module bfpm_ctrl import bfpm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN} state_t;

  state_t state_r, state_nxt;

  // Decode commands from the current state
  always_comb begin
    in_stall   = (state_r != S_IDLE) || sts.res_block;
    cmd.take   = in_valid && !in_stall;
    cmd.issue  = (state_r == S_SCAN);
    cmd.finish = (state_r == S_DRAIN);
  end

  // Advance through the compare
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.take && sts.need_scan) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/bfpm_dp.sv =====
// Datapath for the pattern matcher: pattern and text RAMs, counters, the
// serial comparator and the two-deep result buffer. Depends on bfpm_pkg, bfpm_ram.
module bfpm_dp import bfpm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  ctrl_cmd_t cmd,
  output dp_sts_t   sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [PLEN_W-1:0]  len_r, len_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   cnt_r, cnt_nxt;
  logic [PADDR_W-1:0] wptr_r, wptr_nxt;
  logic [PADDR_W-1:0] k_r, k_nxt;
  logic [PADDR_W-1:0] taddr_r, taddr_nxt;
  logic               mism_r, mism_nxt;
  logic               cmpv_r, cmpv_nxt;
  out_item_t          res_r, res_nxt;
  logic               res_valid_r, res_valid_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               is_pattern, is_text;
  logic               pat_full;
  logic [POS_W-1:0]   pos_inc, cnt_inc;
  logic [CMP_W-1:0]   pos_ext, len_ext, start_val;
  logic [AS_W-1:0]    start_sum;
  logic [PADDR_W-1:0] start_addr;
  logic [SYM_W-1:0]   pat_q, txt_q;
  logic               fin_mis, hit;
  logic               res_move;
  out_item_t          res_new;

  assign is_pattern = (in_data.req_type == REQ_PATTERN);
  assign is_text    = (in_data.req_type == REQ_TEXT);
  assign pat_full   = (len_r == PLEN_W'(PATTERN_MAX));

  // Saturating position and count
  assign pos_inc = (pos_r < POS_W'(TEXT_MAX)) ? pos_r + POS_W'(1) : pos_r;
  assign cnt_inc = (cnt_r < POS_W'(TEXT_MAX)) ? cnt_r + POS_W'(1) : cnt_r;
  assign pos_ext = CMP_W'(pos_inc);
  assign len_ext = CMP_W'(len_r);

  // Oldest window byte that lines up with pattern byte zero
  assign start_sum  = AS_W'(wptr_r) + AS_W'(PATTERN_MAX) + AS_W'(1) - AS_W'(len_r);
  assign start_addr = (start_sum >= AS_W'(PATTERN_MAX)) ?
                      PADDR_W'(start_sum - AS_W'(PATTERN_MAX)) : PADDR_W'(start_sum);

  // Match start from the stored position, one-based
  assign start_val = CMP_W'(pos_r) - CMP_W'(len_r) + CMP_W'(1);

  bfpm_ram #(.WIDTH(SYM_W), .DEPTH(PATTERN_MAX)) u_pat_ram (
    .clk   (clk),
    .we    (cmd.take && is_pattern && !pat_full),
    .waddr (len_r[PADDR_W-1:0]),
    .wdata (in_data.symbol),
    .raddr (k_r),
    .rdata (pat_q)
  );

  bfpm_ram #(.WIDTH(SYM_W), .DEPTH(PATTERN_MAX)) u_txt_ram (
    .clk   (clk),
    .we    (cmd.take && is_text),
    .waddr (wptr_r),
    .wdata (in_data.symbol),
    .raddr (taddr_r),
    .rdata (txt_q)
  );

  assign fin_mis  = mism_r || (pat_q != txt_q);
  assign hit      = !fin_mis;
  assign res_move = res_valid_r && (!out_valid_r || !out_stall);

  // Status toward the controller
  always_comb begin
    sts.res_block  = res_valid_r && !res_move;
    sts.need_scan  = is_text && (len_r != '0) && (pos_ext >= len_ext);
    sts.last_issue = (PLEN_W'(k_r) == len_r - PLEN_W'(1));
  end

  // Result of an item that completes on acceptance
  always_comb begin
    res_new = '0;
    case (in_data.req_type)
      REQ_BEGIN: begin
        res_new = '0;
      end
      REQ_PATTERN: begin
        res_new.match_total      = FIELD_W'(cnt_r);
        res_new.pattern_overflow = pat_full;
      end
      REQ_TEXT: begin
        res_new.match_total = FIELD_W'(cnt_r);
      end
      REQ_END: begin
        res_new.match_total = FIELD_W'(cnt_r);
        res_new.search_done = 1'b1;
        res_new.any_found   = (cnt_r != '0);
      end
      default: begin
        res_new = '0;
      end
    endcase
  end

  // Next-state logic for counters, compare and result buffer
  always_comb begin
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    wptr_nxt      = wptr_r;
    k_nxt         = k_r;
    taddr_nxt     = taddr_r;
    mism_nxt      = mism_r;
    cmpv_nxt      = cmd.issue;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    // Drain the buffer into the output register
    if (res_move) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
      res_valid_nxt = 1'b0;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.take) begin
      case (in_data.req_type)
        REQ_BEGIN: begin
          len_nxt = '0;
          pos_nxt = '0;
          cnt_nxt = '0;
        end
        REQ_PATTERN: begin
          if (!pat_full) begin
            len_nxt = len_r + PLEN_W'(1);
          end
        end
        REQ_TEXT: begin
          pos_nxt  = pos_inc;
          wptr_nxt = (wptr_r == PADDR_W'(PATTERN_MAX - 1)) ? '0 : wptr_r + PADDR_W'(1);
          k_nxt     = '0;
          taddr_nxt = start_addr;
          mism_nxt  = 1'b0;
        end
        default: begin
        end
      endcase
      if (!sts.need_scan) begin
        res_nxt       = res_new;
        res_valid_nxt = 1'b1;
      end
    end

    // Step both read addresses and fold in the previous compare
    if (cmd.issue) begin
      k_nxt     = k_r + PADDR_W'(1);
      taddr_nxt = (taddr_r == PADDR_W'(PATTERN_MAX - 1)) ? '0 : taddr_r + PADDR_W'(1);
    end
    if (cmpv_r && !cmd.finish) begin
      mism_nxt = fin_mis;
    end

    // Close the text item
    if (cmd.finish) begin
      res_nxt                  = '0;
      res_nxt.match_hit        = hit;
      res_nxt.match_start      = hit ? FIELD_W'(start_val) : '0;
      res_nxt.match_total      = hit ? FIELD_W'(cnt_inc) : FIELD_W'(cnt_r);
      res_valid_nxt            = 1'b1;
      if (hit) begin
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      wptr_r      <= '0;
      k_r         <= '0;
      taddr_r     <= '0;
      mism_r      <= 1'b0;
      cmpv_r      <= 1'b0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      wptr_r      <= wptr_nxt;
      k_r         <= k_nxt;
      taddr_r     <= taddr_nxt;
      mism_r      <= mism_nxt;
      cmpv_r      <= cmpv_nxt;
      res_valid_r <= res_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/brute_force_pattern_matcher_top.sv =====
// Begin, pattern, end and short-text transactions are registered straight into the
// result buffer; a text byte that needs a compare takes one pattern-RAM and one
// window-RAM read per cycle through a shared comparator; input stalls until it closes.
// Throughput: 1 item per cycle without compare, while the result buffer is not blocked.
// Reset: synchronous active-low rst_n clears lengths, counters and valids; no RAM sweep.
// Depends on bfpm_pkg, bfpm_ctrl, bfpm_dp.
module brute_force_pattern_matcher_top import bfpm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  bfpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfpm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/bfpm_chk.sv =====
// Port-level checker for the pattern matcher and its bind to the top level.
// Depends on bfpm_pkg.
module bfpm_chk import bfpm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Report a start position exactly on a hit
  a_hit_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.match_hit == (out_data.match_start != '0)))
    else $error("match_start disagrees with match_hit");

  // Hold a stalled input transaction
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input changed");

  // Flag any_found only on an end result with a nonzero count
  a_any_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.any_found |-> out_data.search_done && (out_data.match_total != '0))
    else $error("any_found without end or count");

  // Drop results during reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind brute_force_pattern_matcher_top bfpm_chk u_bfpm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/tb.sv =====
// Self-checking bench for brute_force_pattern_matcher_top: queued search requests,
// a built-in match predictor and a result checker. Depends on bfpm_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
  import bfpm_pkg::*;

  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = PATTERN_MAX + 40;
  localparam int RANDOM_ITEMS = 580;
  localparam int RUN_LIMIT_NS = 12_000_000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Search requests waiting to be sent, and match reports still owed by the block
  in_item_t  requests_to_send [$];
  out_item_t match_reports_due [$];

  int requests_accepted = 0;
  int mismatch_count = 0;
  int send_wait = 0;
  int send_calm = 0;
  int recv_wait = 0;
  int recv_calm = 0;
  logic hold_results = 1'b0;

  // Predictor state: pattern, recent text (entry 0 newest), position and count
  logic [7:0]  pat_bytes [PATTERN_MAX];
  int unsigned pat_len = 0;
  logic [7:0]  recent_text [PATTERN_MAX];
  int unsigned text_seen = 0;
  int unsigned hits_so_far = 0;

  brute_force_pattern_matcher_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin : clock_gen
    forever #4 clk = ~clk;
  end

  // Advance the search state by one request and return the report it should cause
  function automatic out_item_t predict_match(in_item_t req);
    out_item_t rsp;
    bit found;
    int k;
    rsp = '0;
    case (req.req_type)
      REQ_BEGIN: begin
        pat_len = 0;
        text_seen = 0;
        hits_so_far = 0;
        for (k = 0; k < PATTERN_MAX; k++) recent_text[k] = 8'h00;
      end
      REQ_PATTERN: begin
        if (pat_len < PATTERN_MAX) begin
          pat_bytes[pat_len] = req.symbol;
          pat_len++;
        end else begin
          rsp.pattern_overflow = 1'b1;
        end
        rsp.match_total = FIELD_W'(hits_so_far);
      end
      REQ_TEXT: begin
        for (k = PATTERN_MAX - 1; k > 0; k--) recent_text[k] = recent_text[k-1];
        recent_text[0] = req.symbol;
        if (text_seen < TEXT_MAX) text_seen++;
        found = (pat_len != 0) && (text_seen >= pat_len);
        for (k = 0; k < pat_len && found; k++) begin
          if (pat_bytes[k] !== recent_text[pat_len-1-k]) found = 1'b0;
        end
        if (found) begin
          rsp.match_hit = 1'b1;
          rsp.match_start = FIELD_W'(text_seen - pat_len + 1);
          if (hits_so_far < TEXT_MAX) hits_so_far++;
        end
        rsp.match_total = FIELD_W'(hits_so_far);
      end
      default: begin
        rsp.search_done = 1'b1;
        rsp.any_found = (hits_so_far > 0);
        rsp.match_total = FIELD_W'(hits_so_far);
      end
    endcase
    return rsp;
  endfunction

  // Idle cycles before the next transaction; calm stretches run without gaps
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 1) ? $urandom_range(0, 17) : 0;
  endfunction

  function automatic string describe(out_item_t r);
    return $sformatf("hit=%0d start=%0d total=%0d any=%0d done=%0d ovf=%0d",
                     r.match_hit, r.match_start, r.match_total, r.any_found,
                     r.search_done, r.pattern_overflow);
  endfunction

  // Compare one report against the oldest one owed
  task automatic check_report(input out_item_t got);
    out_item_t want;
    if (match_reports_due.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("unexpected result: %s", describe(got));
    end else begin
      want = match_reports_due.pop_front();
      if (got.match_hit !== want.match_hit || got.match_start !== want.match_start ||
          got.match_total !== want.match_total || got.any_found !== want.any_found ||
          got.search_done !== want.search_done ||
          got.pattern_overflow !== want.pattern_overflow) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("mismatch: expected %s", describe(want));
          $display("          actual   %s", describe(got));
        end
      end
    end
  endtask

  task automatic push_request(input logic [1:0] kind, input logic [7:0] sym);
    in_item_t r;
    r.req_type = kind;
    r.symbol = sym;
    requests_to_send.push_back(r);
  endtask

  // One search: begin, pattern over a two-letter alphabet, text with planted copies
  task automatic queue_random_search();
    logic [7:0] letters [2];
    logic [7:0] pat [$];
    int plen, tlen, i, j;
    letters[0] = 8'($urandom);
    letters[1] = 8'($urandom);
    push_request(REQ_BEGIN, 8'($urandom));
    plen = ($urandom_range(0, 19) == 0) ? $urandom_range(5, PATTERN_MAX + 3)
                                         : $urandom_range(0, 4);
    for (i = 0; i < plen; i++) begin
      if (pat.size() < PATTERN_MAX) pat.push_back(letters[$urandom_range(0, 1)]);
      push_request(REQ_PATTERN, pat[pat.size()-1]);
    end
    tlen = (plen > 4) ? $urandom_range(1, 3) : $urandom_range(0, 20);
    for (i = 0; i < tlen; i++) begin
      if (pat.size() > 0 && (plen > 4 || $urandom_range(0, 4) == 0)) begin
        for (j = 0; j < pat.size(); j++) push_request(REQ_TEXT, pat[j]);
      end else begin
        push_request(REQ_TEXT, letters[$urandom_range(0, 1)]);
      end
      // grow the pattern mid-text, or close early and keep streaming
      if ($urandom_range(0, 29) == 0) begin
        if (pat.size() < PATTERN_MAX) pat.push_back(letters[$urandom_range(0, 1)]);
        push_request(REQ_PATTERN, pat[pat.size()-1]);
      end
      if ($urandom_range(0, 29) == 0) push_request(REQ_END, 8'($urandom));
    end
    if ($urandom_range(0, 3) != 0) push_request(REQ_END, 8'($urandom));
  endtask

  // Stimulus, reset and end of run
  initial begin : stimulus
    logic [7:0] long_pat [PATTERN_MAX];
    int i, n;
    int total_requests;
    for (i = 0; i < PATTERN_MAX; i++) recent_text[i] = 8'h00;

    // empty pattern after reset, then an end with nothing found
    push_request(REQ_TEXT, 8'h5A);
    push_request(REQ_END, 8'hFF);
    // pattern longer than the text so far, then hits, then growth after text
    push_request(REQ_BEGIN, 8'hFF);
    push_request(REQ_PATTERN, 8'h00);
    push_request(REQ_PATTERN, 8'hFF);
    push_request(REQ_TEXT, 8'h00);
    push_request(REQ_TEXT, 8'hFF);
    push_request(REQ_TEXT, 8'h00);
    push_request(REQ_TEXT, 8'hFF);
    push_request(REQ_PATTERN, 8'h00);
    push_request(REQ_TEXT, 8'h00);
    push_request(REQ_END, 8'h00);
    push_request(REQ_TEXT, 8'hFF);
    // window bytes seen before the pattern count; overlapping hits
    push_request(REQ_BEGIN, 8'h00);
    push_request(REQ_TEXT, 8'h7E);
    push_request(REQ_PATTERN, 8'h7E);
    push_request(REQ_PATTERN, 8'h7E);
    push_request(REQ_TEXT, 8'h7E);
    push_request(REQ_TEXT, 8'h7E);
    push_request(REQ_TEXT, 8'h81);
    push_request(REQ_END, 8'hA5);

    // full pattern, dropped bytes beyond capacity, longest compares
    push_request(REQ_BEGIN, 8'($urandom));
    for (i = 0; i < PATTERN_MAX; i++) begin
      long_pat[i] = 8'($urandom);
      push_request(REQ_PATTERN, long_pat[i]);
    end
    for (i = 0; i < 3; i++) push_request(REQ_PATTERN, 8'($urandom));
    push_request(REQ_TEXT, 8'($urandom));
    push_request(REQ_TEXT, 8'($urandom));
    for (n = 0; n < 2; n++) begin
      for (i = 0; i < PATTERN_MAX; i++) push_request(REQ_TEXT, long_pat[i]);
    end
    push_request(REQ_END, 8'($urandom));

    // random searches mixed with noise
    n = requests_to_send.size() + RANDOM_ITEMS;
    while (requests_to_send.size() < n) begin
      if ($urandom_range(0, 9) == 0) begin
        for (i = $urandom_range(1, 6); i > 0; i--)
          push_request(2'($urandom_range(0, 3)), 8'($urandom));
      end else begin
        queue_random_search();
      end
    end
    total_requests = requests_to_send.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_accepted < total_requests) @(posedge clk);
    while (match_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("brute_force_pattern_matcher_top test passed");
    end else begin
      $display("brute_force_pattern_matcher_top test failed");
    end
    $finish;
  end

  // Sender: record the accepted transaction, then load the next one after its gap
  always @(posedge clk) begin : drive_requests
    logic offer;
    offer = in_valid;
    if (!rst_n) begin
      offer = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        match_reports_due.push_back(predict_match(in_data));
        requests_accepted++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (requests_to_send.size() > 0) begin
          in_data <= requests_to_send.pop_front();
          offer = 1'b1;
          send_wait = draw_wait(send_calm);
        end
      end
    end
    in_valid <= offer;
  end

  // Receiver: check each accepted transaction, then stall for a drawn number of cycles
  always @(posedge clk) begin : check_results
    if (!rst_n) begin
      recv_wait = 0;
    end else if (out_valid && !out_stall) begin
      check_report(out_data);
      recv_wait = draw_wait(recv_calm);
    end else if (recv_wait > 0) begin
      recv_wait--;
    end
    out_stall <= hold_results || (recv_wait > 0);
  end

  // Hold off the result side for a long stretch so the block backs up its input
  initial begin : long_stall
    while (requests_accepted < HOLD_AT) @(posedge clk);
    hold_results <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_results <= 1'b0;
  end

  initial begin : watchdog
    #RUN_LIMIT_NS;
    $display("brute_force_pattern_matcher_top test failed");
    $finish;
  end

endmodule
